// ===== rtl/core/mhsd_pkg.sv =====
package mhsd_pkg;

	localparam int HEAP_DEPTH = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int SIZE_W = $clog2(HEAP_DEPTH + 1);
	localparam int CHILD_W = ADDR_W + 2;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_SIFT = 2'd2;

	typedef logic signed [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] index;
		logic signed [31:0] value;
		logic [8:0] active_size;
	} heap_req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [7:0] final_index;
		logic [3:0] swap_count;
		logic bad_index;
	} heap_rsp_t;

	typedef struct packed {
		logic load_item;
		logic wr_item;
		logic rd_item;
		logic cap_read;
		logic cap_node;
		logic rd_left;
		logic cap_left;
		logic rd_right;
		logic step;
		logic fin_write;
		logic load_out;
	} mhsd_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic bad_start;
		logic left_ok;
		logic take_child;
	} mhsd_sts_t;

	function automatic word_t to_word(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return word_t'(w[DATA_WIDTH-1:0]);
	endfunction

	function automatic logic signed [31:0] from_word(input word_t w);
		logic signed [63:0] x;
		x = 64'(w);
		return x[31:0];
	endfunction

endpackage

// ===== rtl/core/mhsd_dp.sv =====
module mhsd_dp (
	input logic clk,
	input mhsd_pkg::heap_req_t req,
	input mhsd_pkg::mhsd_cmd_t cmd,
	output mhsd_pkg::mhsd_sts_t sts,
	output mhsd_pkg::heap_rsp_t rsp
);
	import mhsd_pkg::*;

	word_t mem_q [HEAP_DEPTH];
	word_t rdata_q;
	word_t node_q;
	word_t left_q;
	logic [1:0] action_q;
	logic [7:0] index_q;
	logic signed [31:0] value_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] cur_q;
	logic [3:0] swaps_q;
	logic signed [31:0] read_value_q;
	heap_rsp_t rsp_q;

	logic idx_ok;
	logic [CHILD_W-1:0] left_c;
	logic [CHILD_W-1:0] right_c;
	logic right_ok;
	logic left_gt;
	logic right_gt;
	word_t best_val;
	word_t step_val;
	logic [ADDR_W-1:0] step_idx;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	word_t wdata;
	logic we;
	heap_rsp_t rsp_d;

	assign idx_ok = 32'(index_q) < HEAP_DEPTH;
	assign left_c = CHILD_W'({cur_q, 1'b1});
	assign right_c = left_c + CHILD_W'(1);
	assign right_ok = 32'(right_c) < 32'(size_q);
	assign left_gt = left_q > node_q;
	assign best_val = left_gt ? left_q : node_q;
	assign right_gt = right_ok && (rdata_q > best_val);
	assign step_val = right_gt ? rdata_q : left_q;
	assign step_idx = right_gt ? right_c[ADDR_W-1:0] : left_c[ADDR_W-1:0];

	assign sts.action = action_q;
	assign sts.bad_start = 32'(index_q) >= 32'(size_q);
	assign sts.left_ok = 32'(left_c) < 32'(size_q);
	assign sts.take_child = left_gt || right_gt;

	always_comb begin
		if (cmd.rd_item) begin
			raddr = ADDR_W'(index_q);
		end else if (cmd.rd_left) begin
			raddr = left_c[ADDR_W-1:0];
		end else if (cmd.rd_right) begin
			raddr = right_c[ADDR_W-1:0];
		end else begin
			raddr = cur_q;
		end
	end

	always_comb begin
		we = (cmd.wr_item && idx_ok) || cmd.fin_write || cmd.step;
		waddr = cmd.wr_item ? ADDR_W'(index_q) : cur_q;
		if (cmd.wr_item) begin
			wdata = to_word(value_q);
		end else if (cmd.step) begin
			wdata = step_val;
		end else begin
			wdata = node_q;
		end
	end

	always_comb begin
		rsp_d = '0;
		case (action_q)
			ACT_READ: begin
				rsp_d.read_value = read_value_q;
			end
			ACT_SIFT: begin
				if (sts.bad_start) begin
					rsp_d.bad_index = 1'b1;
				end else begin
					rsp_d.final_index = 8'(cur_q);
					rsp_d.swap_count = swaps_q;
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= req.action;
			index_q <= req.index;
			value_q <= req.value;
			size_q <= (32'(req.active_size) > HEAP_DEPTH) ? SIZE_W'(HEAP_DEPTH)
				: SIZE_W'(req.active_size);
			cur_q <= ADDR_W'(req.index);
			swaps_q <= '0;
		end
		if (cmd.cap_read) begin
			read_value_q <= idx_ok ? from_word(rdata_q) : '0;
		end
		if (cmd.cap_node) begin
			node_q <= rdata_q;
		end
		if (cmd.cap_left) begin
			left_q <= rdata_q;
		end
		if (cmd.step) begin
			cur_q <= step_idx;
			if (swaps_q != 4'hF) begin
				swaps_q <= swaps_q + 4'd1;
			end
		end
		if (cmd.load_out) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/core/mhsd_ctrl.sv =====
module mhsd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input mhsd_pkg::mhsd_sts_t sts,
	output mhsd_pkg::mhsd_cmd_t cmd
);
	import mhsd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_WAIT,
		ST_NODE_WAIT,
		ST_LEVEL,
		ST_L_WAIT,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic rsp_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.action)
					ACT_WRITE: begin
						cmd.wr_item = 1'b1;
						state_d = ST_DONE;
					end
					ACT_READ: begin
						cmd.rd_item = 1'b1;
						state_d = ST_RD_WAIT;
					end
					ACT_SIFT: begin
						if (sts.bad_start) begin
							state_d = ST_DONE;
						end else begin
							cmd.rd_item = 1'b1;
							state_d = ST_NODE_WAIT;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_RD_WAIT: begin
				cmd.cap_read = 1'b1;
				state_d = ST_DONE;
			end
			ST_NODE_WAIT: begin
				cmd.cap_node = 1'b1;
				state_d = ST_LEVEL;
			end
			ST_LEVEL: begin
				if (sts.left_ok) begin
					cmd.rd_left = 1'b1;
					state_d = ST_L_WAIT;
				end else begin
					cmd.fin_write = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_L_WAIT: begin
				cmd.cap_left = 1'b1;
				cmd.rd_right = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.take_child) begin
					cmd.step = 1'b1;
					state_d = ST_LEVEL;
				end else begin
					cmd.fin_write = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/max_heap_sift_down_core.sv =====
// Channel | Handshake            | Payload
// req     | req_valid/req_ready  | req (heap_req_t): action, index, value, active_size
// rsp     | rsp_valid/rsp_ready  | rsp (heap_rsp_t): read_value, final_index, swap_count,
//         |                      | bad_index
//
// A sift-down reads the entry, then its left and right children in turn, since the store has
// one read port, and on each swap writes the larger child into the current position.
// The held entry is written where it comes to rest.
// Reset clears the controller and the result valid; the store is not cleared.
// The next item is accepted while a result waits on rsp_ready; a finished item then
// holds in its last state until that result is taken.
module max_heap_sift_down_core (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input mhsd_pkg::heap_req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output mhsd_pkg::heap_rsp_t rsp
);
	import mhsd_pkg::*;

	mhsd_cmd_t cmd;
	mhsd_sts_t sts;

	mhsd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts(sts),
		.cmd(cmd)
	);

	mhsd_dp u_dp (
		.clk(clk),
		.req(req),
		.cmd(cmd),
		.sts(sts),
		.rsp(rsp)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("block accepted two items back to back");

	a_bad_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.bad_index |-> (rsp.final_index == 8'd0) && (rsp.swap_count == 4'd0))
		else $error("bad start result carries a position or swap count");

	a_no_store_write_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |-> !(cmd.wr_item || cmd.fin_write || cmd.step))
		else $error("store written while an item is loaded");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without an item in progress");
`endif

endmodule
